// ===== hdl/kri_pkg.sv =====
// Package for the keyframe record and interpolate block.
// Holds command and event codes, the frame record type and the sequencer states.
// No dependencies.
package kri_pkg;

  // Command codes carried by in_mode.
  typedef enum logic [2:0] {
    MODE_REC_START  = 3'd0,
    MODE_REC_STOP   = 3'd1,
    MODE_TICK       = 3'd2,
    MODE_CAPTURE    = 3'd3,
    MODE_PLAY_START = 3'd4,
    MODE_PLAY_STOP  = 3'd5,
    MODE_SEEK       = 3'd6,
    MODE_NONE       = 3'd7
  } kri_mode_t;

  // Result event codes.
  typedef enum logic [1:0] {
    EVT_UPDATE   = 2'd0,
    EVT_FINISHED = 2'd1,
    EVT_REFUSED  = 2'd2,
    EVT_ACCEPTED = 2'd3
  } kri_event_t;

  // Configuration register indexes.
  localparam logic CFG_INTERVAL = 1'b0;
  localparam logic CFG_SPEED    = 1'b1;

  localparam logic [31:0] INTERVAL_RST = 32'd6554;
  localparam logic [11:0] SPEED_RST    = 12'd256;
  localparam logic [11:0] SPEED_MIN    = 12'd26;
  localparam logic [11:0] SPEED_MAX    = 12'd2560;

  // Number of interpolated fields that go through the shared multiplier.
  localparam int NUM_LERP = 8;

  // One stored frame.
  typedef struct packed {
    logic [31:0] stamp;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] pitch;
    logic [31:0] yaw;
    logic [31:0] roll;
    logic [14:0] battery;
    logic [15:0] signal;
    logic [7:0]  waypoint;
  } kri_frame_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADDT,
    ST_SRCH,
    ST_SCMP,
    ST_RDA,
    ST_RDB,
    ST_RDC,
    ST_DIV,
    ST_LERP,
    ST_EMIT
  } kri_state_t;

endpackage

// ===== hdl/kri_frame_mem.sv =====
// Frame table: one write port and one registered read port.
// Depends on kri_pkg for the frame record type.
module kri_frame_mem
  import kri_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  kri_frame_t     wdata,
  input  logic [AW-1:0]  raddr,
  output kri_frame_t     rdata
);

  kri_frame_t mem [DEPTH];

  // Write a captured frame.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/kri_div.sv =====
// Restoring divider that yields a 16-bit fraction of num over den, one bit a cycle.
// Requires num below den. Depends on kri_pkg only by convention of the project.
module kri_div
  import kri_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [15:0] quo
);

  logic        active_r;
  logic [3:0]  cnt_r;
  logic [32:0] rem_r;
  logic [31:0] den_r;
  logic [15:0] quo_r;
  logic        done_r;
  logic [32:0] shl;

  assign shl  = {rem_r[31:0], 1'b0};
  assign done = done_r;
  assign quo  = quo_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active_r <= 1'b1;
        cnt_r    <= '0;
      end else if (active_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  // One quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      quo_r <= '0;
    end else if (active_r) begin
      if (shl >= {1'b0, den_r}) begin
        rem_r <= shl - {1'b0, den_r};
        quo_r <= {quo_r[14:0], 1'b1};
      end else begin
        rem_r <= shl;
        quo_r <= {quo_r[14:0], 1'b0};
      end
    end
  end

endmodule

// ===== hdl/keyframe_record_interpolate_top.sv =====
// Keyframe record and playback with binary search and linear interpolation.
// Commands other than a playing tick leave busy low; only play start of them gives a result,
// registered in the next cycle. A playing tick keeps busy high through MUL and ADDT when
// playback finishes, and for an update also through the one-read-port search, the 16-step
// divider and the shared multiplier over eight fields. The result is strobed for one cycle,
// in the same cycle that busy falls. The receiver cannot stall.
// Reset is synchronous, active low; the frame table is undefined until written.
module keyframe_record_interpolate_top
  import kri_pkg::*;
#(
  parameter int MAX_FRAMES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_mode,
  input  logic [31:0]        in_time_value,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_pitch,
  input  logic signed [31:0] in_yaw,
  input  logic signed [31:0] in_roll,
  input  logic [14:0]        in_battery,
  input  logic [15:0]        in_signal,
  input  logic [7:0]         in_waypoint,
  output logic               out_valid,
  output logic [1:0]         out_event_res,
  output logic [31:0]        out_time,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_pitch,
  output logic signed [31:0] out_yaw,
  output logic signed [31:0] out_roll,
  output logic [14:0]        out_battery,
  output logic [15:0]        out_signal,
  output logic [7:0]         out_waypoint,
  output logic [9:0]         out_frame_index,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int AW = $clog2(MAX_FRAMES);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAMES);
  localparam logic [AW-1:0] TOP_BIT = AW'(1) << (AW - 1);

  kri_state_t  state_r, state_nxt;
  logic [31:0] interval_r;
  logic [11:0] speed_r;
  logic [CW-1:0] count_r;
  logic        rec_r, play_r;
  logic [31:0] ctimer_r, ptimer_r, last_r;
  logic [31:0] tv_r;
  logic [43:0] tprod_r;
  logic [AW-1:0] idx_r, bit_r, cand;
  logic [3:0]  lcnt_r;
  logic [15:0] alpha_r;
  kri_frame_t  row_a_r, row_b_r, rdata, wdata;
  logic [AW-1:0] raddr;
  logic        mem_we;
  logic signed [50:0] lprod_r;
  logic [31:0] res_r [NUM_LERP];

  logic        acc;
  kri_mode_t   mode;
  logic [32:0] csum;
  logic [36:0] psum;
  logic [31:0] psat, new_stamp, last_eff;
  logic [32:0] isum;
  logic        div_start, div_done;
  logic [15:0] div_quo;
  logic [2:0]  kk, kprev;
  logic signed [32:0] fa_k, fb_k, fa_p;
  logic signed [33:0] ldiff;
  logic signed [34:0] lsum;

  // Field k of a frame, extended to 33 signed bits.
  function automatic logic signed [32:0] fld(input kri_frame_t f, input logic [2:0] k);
    logic signed [32:0] v;
    unique case (k)
      3'd0: v = {f.x[31], f.x};
      3'd1: v = {f.y[31], f.y};
      3'd2: v = {f.z[31], f.z};
      3'd3: v = {f.pitch[31], f.pitch};
      3'd4: v = {f.yaw[31], f.yaw};
      3'd5: v = {f.roll[31], f.roll};
      3'd6: v = {18'b0, f.battery};
      3'd7: v = {17'b0, f.signal};
    endcase
    return v;
  endfunction

  assign busy     = (state_r != ST_IDLE);
  assign acc      = start && !busy;
  assign mode     = kri_mode_t'(in_mode);
  assign cand     = idx_r | bit_r;
  assign last_eff = (count_r == '0) ? 32'd0 : last_r;

  // Saturating time sums.
  assign csum      = {1'b0, ctimer_r} + {1'b0, in_time_value};
  assign psum      = {5'b0, ptimer_r} + {1'b0, tprod_r[43:8]};
  assign psat      = (|psum[36:32]) ? 32'hFFFF_FFFF : psum[31:0];
  assign isum      = {1'b0, last_r} + {1'b0, interval_r};
  assign new_stamp = (count_r == '0) ? 32'd0 : (isum[32] ? 32'hFFFF_FFFF : isum[31:0]);

  // Capture write data.
  assign mem_we = acc && (mode == MODE_CAPTURE) && (ctimer_r >= interval_r)
                  && (count_r < MAX_CNT);
  always_comb begin
    wdata.stamp    = new_stamp;
    wdata.x        = in_pos_x;
    wdata.y        = in_pos_y;
    wdata.z        = in_pos_z;
    wdata.pitch    = in_pitch;
    wdata.yaw      = in_yaw;
    wdata.roll     = in_roll;
    wdata.battery  = in_battery;
    wdata.signal   = in_signal;
    wdata.waypoint = in_waypoint;
  end

  // Read address follows the sequencer.
  always_comb begin
    priority case (state_r)
      ST_RDA:  raddr = idx_r;
      ST_RDB:  raddr = idx_r + AW'(1);
      default: raddr = cand;
    endcase
  end

  kri_frame_mem #(.DEPTH(MAX_FRAMES), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign div_start = (state_r == ST_RDC);

  kri_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (ptimer_r - row_a_r.stamp),
    .den   (rdata.stamp - row_a_r.stamp),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Shared multiply-add for the lerp: multiply field k, add field k-1.
  assign kk    = lcnt_r[2:0];
  assign kprev = kk - 3'd1;
  assign fa_k  = fld(row_a_r, kk);
  assign fb_k  = fld(row_b_r, kk);
  assign fa_p  = fld(row_a_r, kprev);
  assign ldiff = 34'(fb_k) - 34'(fa_k);
  assign lsum  = 35'(fa_p) + 35'(lprod_r >>> 16);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && (mode == MODE_TICK) && play_r) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_ADDT;
      ST_ADDT: state_nxt = (psat >= last_eff) ? ST_IDLE : ST_SRCH;
      ST_SRCH: begin
        if ({1'b0, cand} < count_r) begin
          state_nxt = ST_SCMP;
        end else if (bit_r[0]) begin
          state_nxt = ST_RDA;
        end
      end
      ST_SCMP: state_nxt = bit_r[0] ? ST_RDA : ST_SRCH;
      ST_RDA:  state_nxt = ST_RDB;
      ST_RDB:  state_nxt = ST_RDC;
      ST_RDC:  state_nxt = ST_DIV;
      ST_DIV:  state_nxt = div_done ? ST_LERP : ST_DIV;
      ST_LERP: state_nxt = (lcnt_r == 4'(NUM_LERP)) ? ST_EMIT : ST_LERP;
      ST_EMIT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control state, configuration and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r      <= INTERVAL_RST;
      speed_r         <= SPEED_RST;
      count_r         <= '0;
      rec_r           <= 1'b0;
      play_r          <= 1'b0;
      ctimer_r        <= '0;
      ptimer_r        <= '0;
      last_r          <= '0;
      idx_r           <= '0;
      bit_r           <= '0;
      lcnt_r          <= '0;
      out_valid       <= 1'b0;
      out_event_res   <= EVT_UPDATE;
      out_time        <= '0;
      out_pos_x       <= '0;
      out_pos_y       <= '0;
      out_pos_z       <= '0;
      out_pitch       <= '0;
      out_yaw         <= '0;
      out_roll        <= '0;
      out_battery     <= '0;
      out_signal      <= '0;
      out_waypoint    <= '0;
      out_frame_index <= '0;
    end else begin
      out_valid <= 1'b0;

      // Configuration writes; speed saturates into its legal range.
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INTERVAL: interval_r <= cfg_wdata;
          CFG_SPEED: begin
            if (cfg_wdata[11:0] < SPEED_MIN) begin
              speed_r <= SPEED_MIN;
            end else if (cfg_wdata[11:0] > SPEED_MAX) begin
              speed_r <= SPEED_MAX;
            end else begin
              speed_r <= cfg_wdata[11:0];
            end
          end
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (acc) begin
            unique case (mode)
              MODE_REC_START: begin
                count_r  <= '0;
                rec_r    <= 1'b1;
                play_r   <= 1'b0;
                ctimer_r <= '0;
              end
              MODE_REC_STOP: rec_r <= 1'b0;
              MODE_TICK: begin
                if (rec_r) begin
                  ctimer_r <= csum[32] ? 32'hFFFF_FFFF : csum[31:0];
                end
              end
              MODE_CAPTURE: begin
                if (ctimer_r >= interval_r) begin
                  ctimer_r <= '0;
                  if (count_r < MAX_CNT) begin
                    count_r <= count_r + CW'(1);
                    last_r  <= new_stamp;
                  end
                end
              end
              MODE_PLAY_START: begin
                out_valid <= 1'b1;
                out_time        <= '0;
                out_pos_x       <= '0;
                out_pos_y       <= '0;
                out_pos_z       <= '0;
                out_pitch       <= '0;
                out_yaw         <= '0;
                out_roll        <= '0;
                out_battery     <= '0;
                out_signal      <= '0;
                out_waypoint    <= '0;
                out_frame_index <= '0;
                if (count_r == '0) begin
                  out_event_res <= EVT_REFUSED;
                end else begin
                  out_event_res <= EVT_ACCEPTED;
                  play_r        <= 1'b1;
                  rec_r         <= 1'b0;
                  ptimer_r      <= '0;
                end
              end
              MODE_PLAY_STOP: play_r <= 1'b0;
              MODE_SEEK: ptimer_r <= (in_time_value > last_eff) ? last_eff : in_time_value;
              MODE_NONE: ;
            endcase
          end
        end
        ST_ADDT: begin
          ptimer_r <= psat;
          idx_r    <= '0;
          bit_r    <= TOP_BIT;
          if (psat >= last_eff) begin
            play_r          <= 1'b0;
            out_valid       <= 1'b1;
            out_event_res   <= EVT_FINISHED;
            out_time        <= '0;
            out_pos_x       <= '0;
            out_pos_y       <= '0;
            out_pos_z       <= '0;
            out_pitch       <= '0;
            out_yaw         <= '0;
            out_roll        <= '0;
            out_battery     <= '0;
            out_signal      <= '0;
            out_waypoint    <= '0;
            out_frame_index <= '0;
          end
        end
        ST_SRCH: begin
          if (!({1'b0, cand} < count_r)) begin
            bit_r <= bit_r >> 1;
          end
        end
        ST_SCMP: begin
          if (rdata.stamp <= ptimer_r) begin
            idx_r <= cand;
          end
          bit_r <= bit_r >> 1;
        end
        ST_DIV: lcnt_r <= '0;
        ST_LERP: lcnt_r <= lcnt_r + 4'd1;
        ST_EMIT: begin
          out_valid       <= 1'b1;
          out_event_res   <= EVT_UPDATE;
          out_time        <= ptimer_r;
          out_pos_x       <= res_r[0];
          out_pos_y       <= res_r[1];
          out_pos_z       <= res_r[2];
          out_pitch       <= res_r[3];
          out_yaw         <= res_r[4];
          out_roll        <= res_r[5];
          out_battery     <= res_r[6][14:0];
          out_signal      <= res_r[7][15:0];
          out_waypoint    <= alpha_r[15] ? row_b_r.waypoint : row_a_r.waypoint;
          out_frame_index <= 10'(idx_r);
        end
        default: ;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (acc) begin
      tv_r <= in_time_value;
    end
    if (state_r == ST_MUL) begin
      tprod_r <= 44'(tv_r) * 44'(speed_r);
    end
    if (state_r == ST_RDB) begin
      row_a_r <= rdata;
    end
    if (state_r == ST_RDC) begin
      row_b_r <= rdata;
    end
    if (div_done) begin
      alpha_r <= div_quo;
    end
    if (state_r == ST_LERP) begin
      if (lcnt_r != 4'(NUM_LERP)) begin
        lprod_r <= 51'(ldiff) * 51'($signed({1'b0, alpha_r}));
      end
      if (lcnt_r != 4'd0) begin
        res_r[kprev] <= lsum[31:0];
      end
    end
  end

endmodule
